// ----- rtl/ctfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Checksummed text frame parser package
// Request types, frame kinds, character codes and small decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ctfp_pkg;

  // Input request: one character of the line.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_line;
  } ctfp_in_t;

  // Result request.
  typedef struct packed {
    logic [3:0]         frame_kind;
    logic signed [11:0] temperature;
    logic [2:0]         mode_value;
    logic [19:0]        frequency;
    logic [6:0]         duty_value;
    logic [3:0]         point_count;
    logic [3:0]         point_index;
    logic signed [15:0] point_temp;
    logic [7:0]         point_duty;
    logic               last_result;
  } ctfp_out_t;

  // Frame kinds.
  localparam logic [3:0] KIND_REJECT   = 4'd0;
  localparam logic [3:0] KIND_CPU_TEMP = 4'd1;
  localparam logic [3:0] KIND_GPU_TEMP = 4'd2;
  localparam logic [3:0] KIND_STATUS   = 4'd3;
  localparam logic [3:0] KIND_CURVE_Q  = 4'd4;
  localparam logic [3:0] KIND_CURVE_S  = 4'd5;
  localparam logic [3:0] KIND_MODE     = 4'd6;
  localparam logic [3:0] KIND_FREQ     = 4'd7;
  localparam logic [3:0] KIND_DUTY     = 4'd8;
  localparam logic [3:0] KIND_SAFETY   = 4'd9;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FREQ_MIN = 2'd0;
  localparam logic [1:0] CFG_FREQ_MAX = 2'd1;
  localparam logic [1:0] CFG_MIN_DUTY = 2'd2;

  // Characters.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Tags as they sit in the four-byte shift register.
  localparam logic [31:0] TAG_CPU = 32'h4350_552C;
  localparam logic [31:0] TAG_GPU = 32'h4750_552C;
  localparam logic [31:0] TAG_STA = 32'h5354_412C;
  localparam logic [31:0] TAG_FCQ = 32'h4643_512C;
  localparam logic [31:0] TAG_FCV = 32'h4643_562C;
  localparam logic [31:0] TAG_MOD = 32'h4D4F_442C;
  localparam logic [31:0] TAG_FRQ = 32'h4652_512C;
  localparam logic [31:0] TAG_DUT = 32'h4455_542C;
  localparam logic [31:0] TAG_SAF = 32'h0053_4146;

  // Saturation bound of parsed magnitudes.
  localparam int unsigned ACC_W   = 27;
  localparam logic [26:0] NUM_CAP = 27'd100000000;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  // Returns {valid, value}.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] lc;
    logic [4:0] r;
    lc = to_lower(c);
    r  = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (lc >= 8'h61 && lc <= 8'h66) r = {1'b1, 4'(lc - 8'h57)};
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Expected letter of the words nan (word 0) and inf (word 1).
  function automatic logic [7:0] word_letter(input logic word, input logic [1:0] pos);
    logic [7:0] r;
    case ({word, pos})
      3'b000:  r = 8'h6E;
      3'b001:  r = 8'h61;
      3'b010:  r = 8'h6E;
      3'b100:  r = 8'h69;
      3'b101:  r = 8'h6E;
      3'b110:  r = 8'h66;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ctfp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered, enable-held read.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/checksummed_text_frame_parser.sv -----
// ----------------------------------------------------------------------------
// Checksummed text frame parser
// Parses $TYPE,PAYLOAD*XX lines byte by byte, checks the XOR checksum and
// classifies the frame; fan curve points are kept in on-chip RAM.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------
//  in_     | input     | in_valid / in_stall | ctfp_in_t  (one character)
//  out_    | output    | out_valid/out_stall | ctfp_out_t (one result)
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// Every character is parsed in the cycle that accepts it, so one request per
// cycle is taken while a line is in progress and no curve set is emitted. At
// line end one result goes to the output register; a curve set instead reads
// its points from the curve RAMs, one point per cycle when the output is free,
// with the input stalled until the last point is loaded. Outside an emission,
// a character without end of line is accepted even while a result waits.
// Reset is synchronous and active low; the curve RAMs are not cleared, since
// a curve result only reads points written earlier in the same line.
//
`default_nettype none

module checksummed_text_frame_parser #(
  parameter int MAX_POINTS = 10,
  parameter int MAX_LINE   = 255
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ctfp_pkg::ctfp_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ctfp_pkg::ctfp_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [19:0]         cfg_wdata
);

  import ctfp_pkg::*;

  localparam int PT_W  = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int POS_W = $clog2(MAX_LINE + 1);

  // Line phases.
  localparam logic [2:0] PH_DOLLAR = 3'd0;
  localparam logic [2:0] PH_DATA   = 3'd1;
  localparam logic [2:0] PH_CS1    = 3'd2;
  localparam logic [2:0] PH_CS2    = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;

  // Number parser phases.
  localparam logic [2:0] NP_LEAD = 3'd0;
  localparam logic [2:0] NP_SIGN = 3'd1;
  localparam logic [2:0] NP_INT  = 3'd2;
  localparam logic [2:0] NP_FRAC = 3'd3;
  localparam logic [2:0] NP_WORD = 3'd4;
  localparam logic [2:0] NP_DONE = 3'd5;

  // Payload modes.
  localparam logic [1:0] PM_NONE  = 2'd0;
  localparam logic [1:0] PM_TEMP  = 2'd1;
  localparam logic [1:0] PM_INT   = 2'd2;
  localparam logic [1:0] PM_CURVE = 2'd3;

  // Curve fields.
  localparam logic [1:0] CF_COUNT = 2'd0;
  localparam logic [1:0] CF_TEMP  = 2'd1;
  localparam logic [1:0] CF_DUTY  = 2'd2;
  localparam logic [1:0] CF_DONE  = 2'd3;

  // Configuration.
  logic [19:0] freq_min_r, freq_max_r;
  logic [6:0]  min_duty_r;

  // Line state.
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [31:0]      tag_r, tag_nxt;
  logic [7:0]       dlen_r, dlen_nxt;
  logic [7:0]       rcs_r, rcs_nxt;
  logic             err_r, err_nxt;
  logic [1:0]       pmode_r, pmode_nxt;
  logic [1:0]       field_r, field_nxt;
  logic [CNT_W-1:0] point_r, point_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;

  // Number parser state. Flags: negative, digit seen, sticky, nan/inf.
  logic [2:0]       np_r, np_nxt;
  logic             nfloat_r, nfloat_nxt;
  logic             nseen_r, nseen_nxt;
  logic             nfrac_r, nfrac_nxt;
  logic [3:0]       tenth_r, tenth_nxt;
  logic [1:0]       match_r, match_nxt;
  logic             word_r, word_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             fneg_r, fneg_nxt;
  logic             fdig_r, fdig_nxt;
  logic             fsticky_r, fsticky_nxt;
  logic             fnan_r, fnan_nxt;

  // Number parser step for the current character.
  logic [2:0]       nf_np;
  logic             nf_seen, nf_frac, nf_word, nf_term;
  logic [3:0]       nf_tenth;
  logic [1:0]       nf_match;
  logic [ACC_W-1:0] nf_acc;
  logic             nf_neg, nf_dig, nf_sticky, nf_nan;

  // Emission of curve points and the output register.
  logic             emit_r, emit_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [PT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] etotal_r, etotal_nxt;
  logic             oval_r, oval_nxt;
  ctfp_out_t        odata_r, odata_nxt;

  // Curve RAM ports.
  logic             t_we, d_we, ram_re;
  logic [PT_W-1:0]  ram_waddr, ram_raddr;
  logic [15:0]      t_wdata, t_rdata;
  logic [7:0]       d_wdata, d_rdata;

  logic       acc_in, out_free;
  logic [7:0] c;

  assign c        = in_data.rx_byte;
  assign out_free = !oval_r || !out_stall;
  // A line end needs a free output slot; curve emission owns the RAM port.
  assign in_stall = emit_r || (in_data.end_of_line && !out_free);
  assign acc_in   = in_valid && !in_stall;
  assign out_valid = oval_r;
  assign out_data  = odata_r;

  ctfp_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_temp_ram (
    .clk(clk), .we(t_we), .waddr(ram_waddr), .wdata(t_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(t_rdata)
  );

  ctfp_ram #(.WIDTH(8), .DEPTH(MAX_POINTS)) u_duty_ram (
    .clk(clk), .we(d_we), .waddr(ram_waddr), .wdata(d_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(d_rdata)
  );

  // Decimal number recogniser: one accepted character a cycle. A character
  // ending the number only moves the phase to done and is not part of it.
  always_comb begin
    logic       dig, as_sign;
    logic [3:0] d;
    logic [7:0] lc;
    logic [30:0] prod;
    dig      = (c >= 8'h30) && (c <= 8'h39);
    d        = dig ? 4'(c - 8'h30) : 4'd0;
    lc       = to_lower(c);
    prod     = (31'(acc_r) << 3) + (31'(acc_r) << 1) + 31'(d);
    as_sign  = 1'b0;
    nf_np    = np_r;
    nf_seen  = nseen_r;
    nf_frac  = nfrac_r;
    nf_word  = word_r;
    nf_tenth = tenth_r;
    nf_match = match_r;
    nf_acc   = acc_r;
    nf_neg   = fneg_r;
    nf_dig   = fdig_r;
    nf_sticky = fsticky_r;
    nf_nan   = fnan_r;
    nf_term  = 1'b0;
    case (np_r)
      NP_LEAD: begin
        if (is_blank(c)) begin
          nf_seen = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          if (c == CH_MINUS) nf_neg = 1'b1;
          nf_seen = 1'b1;
          nf_np   = NP_SIGN;
        end else begin
          as_sign = 1'b1;
        end
      end
      NP_SIGN: as_sign = 1'b1;
      NP_INT: begin
        if (dig) begin
          nf_acc = (prod > 31'(NUM_CAP)) ? NUM_CAP : ACC_W'(prod);
        end else if (nfloat_r && c == CH_DOT) begin
          nf_np = NP_FRAC;
        end else begin
          nf_np = NP_DONE;
          nf_term = 1'b1;
        end
      end
      NP_FRAC: begin
        if (dig) begin
          if (!nfrac_r) begin
            nf_tenth = d;
            nf_frac  = 1'b1;
          end else if (d != 4'd0) begin
            nf_sticky = 1'b1;
          end
          nf_dig = 1'b1;
        end else begin
          nf_np = NP_DONE;
          nf_term = 1'b1;
        end
      end
      NP_WORD: begin
        if (match_r != 2'd3 && lc == word_letter(word_r, match_r)) begin
          nf_match = match_r + 2'd1;
          if (match_r == 2'd2) nf_nan = 1'b1;
        end else begin
          nf_np = NP_DONE;
          nf_term = 1'b1;
        end
      end
      default: ;
    endcase
    if (as_sign) begin
      if (dig) begin
        nf_acc = ACC_W'(d);
        nf_dig = 1'b1;
        nf_np  = NP_INT;
      end else if (nfloat_r && c == CH_DOT) begin
        nf_seen = 1'b1;
        nf_np   = NP_FRAC;
      end else if (nfloat_r && (lc == 8'h6E || lc == 8'h69)) begin
        nf_word  = (lc == 8'h69);
        nf_match = 2'd1;
        nf_seen  = 1'b1;
        nf_np    = NP_WORD;
      end else begin
        nf_np = NP_DONE;
        nf_term = 1'b1;
      end
    end
  end

  // Main per-character update, line end decision and curve emission.
  always_comb begin
    logic       feed, ok, cbad, negv;
    logic [4:0] h;
    logic [16:0] cmag;
    logic [11:0] tmag;
    logic       tbad;
    ctfp_out_t  res;
    pos_nxt = pos_r;  xor_nxt = xor_r;  phase_nxt = phase_r;  tag_nxt = tag_r;
    dlen_nxt = dlen_r; rcs_nxt = rcs_r; err_nxt = err_r;      pmode_nxt = pmode_r;
    field_nxt = field_r; point_nxt = point_r; total_nxt = total_r;
    np_nxt = np_r; nfloat_nxt = nfloat_r; nseen_nxt = nseen_r; nfrac_nxt = nfrac_r;
    tenth_nxt = tenth_r; match_nxt = match_r; word_nxt = word_r; acc_nxt = acc_r;
    fneg_nxt = fneg_r; fdig_nxt = fdig_r; fsticky_nxt = fsticky_r; fnan_nxt = fnan_r;
    emit_nxt = emit_r; rd_vld_nxt = rd_vld_r; rd_idx_nxt = rd_idx_r; etotal_nxt = etotal_r;
    oval_nxt = oval_r && out_stall;
    odata_nxt = odata_r;
    t_we = 1'b0; d_we = 1'b0; ram_re = 1'b0;
    ram_waddr = point_r[PT_W-1:0];
    ram_raddr = rd_idx_r;
    t_wdata = 16'd0;
    d_wdata = 8'd0;
    feed = 1'b0;
    ok   = 1'b0;
    tbad = 1'b0;
    h    = hex_val(c);
    negv = fneg_r && (acc_r != '0);
    cbad = fnan_r || (!fdig_r && nseen_r);
    cmag = 17'(acc_r[11:0]) * 17'd10 + 17'(tenth_r);
    tmag = 12'(acc_r[7:0]) * 12'd10 + 12'(tenth_r);
    res  = '0;

    if (acc_in) begin
      if (pos_r >= POS_W'(MAX_LINE)) err_nxt = 1'b1;
      else pos_nxt = pos_r + POS_W'(1);
      if (!err_nxt) begin
        case (phase_r)
          PH_DOLLAR: begin
            if (c == CH_DOLLAR) phase_nxt = PH_DATA;
            else err_nxt = 1'b1;
          end
          PH_DATA: begin
            if (c == CH_STAR) begin
              feed = 1'b1;
              phase_nxt = PH_CS1;
            end else begin
              xor_nxt = xor_r ^ c;
              if (dlen_r < 8'd4) begin
                tag_nxt  = {tag_r[23:0], c};
                dlen_nxt = dlen_r + 8'd1;
                if (dlen_r == 8'd3) begin
                  np_nxt = NP_LEAD; nseen_nxt = 1'b0; nfrac_nxt = 1'b0;
                  tenth_nxt = 4'd0; match_nxt = 2'd0; word_nxt = 1'b0; acc_nxt = '0;
                  fneg_nxt = 1'b0; fdig_nxt = 1'b0; fsticky_nxt = 1'b0; fnan_nxt = 1'b0;
                  if (tag_nxt == TAG_CPU || tag_nxt == TAG_GPU) begin
                    pmode_nxt = PM_TEMP;
                    nfloat_nxt = 1'b1;
                  end else if (tag_nxt == TAG_MOD || tag_nxt == TAG_FRQ ||
                               tag_nxt == TAG_DUT) begin
                    pmode_nxt = PM_INT;
                    nfloat_nxt = 1'b0;
                  end else if (tag_nxt == TAG_FCV) begin
                    pmode_nxt = PM_CURVE;
                    field_nxt = CF_COUNT;
                    nfloat_nxt = 1'b0;
                  end else begin
                    nfloat_nxt = 1'b0;
                  end
                end
              end else begin
                if (dlen_r != 8'd255) dlen_nxt = dlen_r + 8'd1;
                feed = 1'b1;
              end
            end
          end
          PH_CS1: begin
            if (!h[4]) err_nxt = 1'b1;
            else begin
              rcs_nxt = {h[3:0], 4'd0};
              phase_nxt = PH_CS2;
            end
          end
          PH_CS2: begin
            if (!h[4]) err_nxt = 1'b1;
            else begin
              rcs_nxt = {rcs_r[7:4], h[3:0]};
              phase_nxt = PH_TAIL;
            end
          end
          default: ;
        endcase
      end

      // Payload numbers.
      if (feed && (pmode_r == PM_TEMP || pmode_r == PM_INT ||
                   (pmode_r == PM_CURVE && field_r != CF_DONE))) begin
        np_nxt = nf_np; nseen_nxt = nf_seen; nfrac_nxt = nf_frac; word_nxt = nf_word;
        tenth_nxt = nf_tenth; match_nxt = nf_match; acc_nxt = nf_acc;
        fneg_nxt = nf_neg; fdig_nxt = nf_dig; fsticky_nxt = nf_sticky; fnan_nxt = nf_nan;
        if (pmode_r == PM_CURVE && nf_term) begin
          // A curve field has ended; the number registers still hold it.
          np_nxt = NP_LEAD; nseen_nxt = 1'b0; nfrac_nxt = 1'b0; tenth_nxt = 4'd0;
          match_nxt = 2'd0; word_nxt = 1'b0; acc_nxt = '0; fneg_nxt = 1'b0;
          fdig_nxt = 1'b0; fsticky_nxt = 1'b0; fnan_nxt = 1'b0;
          if (cbad) begin
            err_nxt = 1'b1;
            field_nxt = CF_DONE;
          end else begin
            case (field_r)
              CF_COUNT: begin
                if (fneg_r || acc_r < ACC_W'(2) || acc_r > ACC_W'(MAX_POINTS) ||
                    c != CH_COMMA) begin
                  err_nxt = 1'b1;
                  field_nxt = CF_DONE;
                end else begin
                  total_nxt = CNT_W'(acc_r);
                  point_nxt = '0;
                  field_nxt = CF_TEMP;
                  nfloat_nxt = 1'b1;
                end
              end
              CF_TEMP: begin
                t_we = 1'b1;
                if (acc_r > ACC_W'(3276) || (acc_r == ACC_W'(3276) &&
                    tenth_r > (fneg_r ? 4'd8 : 4'd7))) begin
                  t_wdata = fneg_r ? 16'h8000 : 16'h7FFF;
                end else begin
                  t_wdata = fneg_r ? 16'(-cmag) : cmag[15:0];
                end
                if (c != CH_COMMA) begin
                  err_nxt = 1'b1;
                  field_nxt = CF_DONE;
                end else begin
                  field_nxt = CF_DUTY;
                  nfloat_nxt = 1'b0;
                end
              end
              CF_DUTY: begin
                d_we = 1'b1;
                d_wdata = fneg_r ? 8'(-acc_r[7:0]) : acc_r[7:0];
                point_nxt = point_r + CNT_W'(1);
                if (point_nxt >= total_r) begin
                  field_nxt = CF_DONE;
                end else if (c != CH_COMMA) begin
                  err_nxt = 1'b1;
                  field_nxt = CF_DONE;
                end else begin
                  field_nxt = CF_TEMP;
                  nfloat_nxt = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end

      // Line end: the data fields are final, as only the checksum bytes or
      // the tail can carry the end of an acceptable line.
      if (in_data.end_of_line) begin
        ok = !err_nxt && phase_nxt == PH_TAIL && dlen_r >= 8'd3 && rcs_nxt == xor_r;
        res.last_result = 1'b1;
        res.frame_kind  = KIND_REJECT;
        if (ok) begin
          if ((tag_r == TAG_CPU || tag_r == TAG_GPU) && dlen_r >= 8'd6) begin
            if (fneg_r) tbad = acc_r > ACC_W'(50) ||
                               (acc_r == ACC_W'(50) && (tenth_r != 4'd0 || fsticky_r));
            else        tbad = acc_r > ACC_W'(150) ||
                               (acc_r == ACC_W'(150) && (tenth_r != 4'd0 || fsticky_r));
            if (!fnan_r && !tbad) begin
              res.frame_kind  = (tag_r == TAG_CPU) ? KIND_CPU_TEMP : KIND_GPU_TEMP;
              res.temperature = fneg_r ? -$signed(tmag) : $signed(tmag);
            end
          end else if (tag_r == TAG_STA && dlen_r == 8'd5) begin
            res.frame_kind = KIND_STATUS;
          end else if (tag_r == TAG_FCQ && dlen_r == 8'd5) begin
            res.frame_kind = KIND_CURVE_Q;
          end else if (tag_r == TAG_FCV && dlen_r >= 8'd6) begin
            if (field_r == CF_DONE && total_r >= CNT_W'(2)) begin
              emit_nxt   = 1'b1;
              etotal_nxt = total_r;
              ram_re     = 1'b1;
              ram_raddr  = '0;
              rd_idx_nxt = '0;
              rd_vld_nxt = 1'b1;
            end
          end else if (tag_r == TAG_MOD && dlen_r >= 8'd5) begin
            if (!fneg_r && acc_r >= ACC_W'(1) && acc_r <= ACC_W'(4)) begin
              res.frame_kind = KIND_MODE;
              res.mode_value = acc_r[2:0];
            end
          end else if (tag_r == TAG_FRQ && dlen_r >= 8'd6) begin
            if (!negv && acc_r >= ACC_W'(freq_min_r) && acc_r <= ACC_W'(freq_max_r)) begin
              res.frame_kind = KIND_FREQ;
              res.frequency  = acc_r[19:0];
            end
          end else if (tag_r == TAG_DUT && dlen_r >= 8'd5) begin
            if (!negv && acc_r >= ACC_W'(min_duty_r) && acc_r <= ACC_W'(100)) begin
              res.frame_kind = KIND_DUTY;
              res.duty_value = acc_r[6:0];
            end
          end else if (tag_r == TAG_SAF && dlen_r == 8'd3) begin
            res.frame_kind = KIND_SAFETY;
          end
        end
        if (!emit_nxt) begin
          oval_nxt  = 1'b1;
          odata_nxt = res;
        end
        // Clear the line; the curve RAMs keep their contents.
        pos_nxt = '0; xor_nxt = 8'd0; phase_nxt = PH_DOLLAR; tag_nxt = 32'd0;
        dlen_nxt = 8'd0; rcs_nxt = 8'd0; err_nxt = 1'b0; pmode_nxt = PM_NONE;
        field_nxt = CF_COUNT; point_nxt = '0; total_nxt = '0;
        np_nxt = NP_LEAD; nfloat_nxt = 1'b0; nseen_nxt = 1'b0; nfrac_nxt = 1'b0;
        tenth_nxt = 4'd0; match_nxt = 2'd0; word_nxt = 1'b0; acc_nxt = '0;
        fneg_nxt = 1'b0; fdig_nxt = 1'b0; fsticky_nxt = 1'b0; fnan_nxt = 1'b0;
      end
    end

    // Curve points leave one a cycle: the RAM output holds point rd_idx_r
    // until the output register can take it, then the next read is issued.
    if (emit_r && rd_vld_r && out_free) begin
      res = '0;
      res.frame_kind  = KIND_CURVE_S;
      res.point_count = 4'(etotal_r);
      res.point_index = 4'(rd_idx_r);
      res.point_temp  = $signed(t_rdata);
      res.point_duty  = d_rdata;
      res.last_result = (CNT_W'(rd_idx_r) + CNT_W'(1) == etotal_r);
      oval_nxt  = 1'b1;
      odata_nxt = res;
      if (res.last_result) begin
        emit_nxt   = 1'b0;
        rd_vld_nxt = 1'b0;
      end else begin
        rd_idx_nxt = rd_idx_r + PT_W'(1);
        ram_re     = 1'b1;
        ram_raddr  = rd_idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_min_r <= 20'd1000;
      freq_max_r <= 20'd100000;
      min_duty_r <= 7'd20;
      pos_r <= '0; xor_r <= 8'd0; phase_r <= PH_DOLLAR; tag_r <= 32'd0;
      dlen_r <= 8'd0; rcs_r <= 8'd0; err_r <= 1'b0; pmode_r <= PM_NONE;
      field_r <= CF_COUNT; point_r <= '0; total_r <= '0;
      np_r <= NP_LEAD; nfloat_r <= 1'b0; nseen_r <= 1'b0; nfrac_r <= 1'b0;
      tenth_r <= 4'd0; match_r <= 2'd0; word_r <= 1'b0; acc_r <= '0;
      fneg_r <= 1'b0; fdig_r <= 1'b0; fsticky_r <= 1'b0; fnan_r <= 1'b0;
      emit_r <= 1'b0; rd_vld_r <= 1'b0; rd_idx_r <= '0; etotal_r <= '0;
      oval_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FREQ_MIN: freq_min_r <= cfg_wdata;
          CFG_FREQ_MAX: freq_max_r <= cfg_wdata;
          CFG_MIN_DUTY: min_duty_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      pos_r <= pos_nxt; xor_r <= xor_nxt; phase_r <= phase_nxt; tag_r <= tag_nxt;
      dlen_r <= dlen_nxt; rcs_r <= rcs_nxt; err_r <= err_nxt; pmode_r <= pmode_nxt;
      field_r <= field_nxt; point_r <= point_nxt; total_r <= total_nxt;
      np_r <= np_nxt; nfloat_r <= nfloat_nxt; nseen_r <= nseen_nxt; nfrac_r <= nfrac_nxt;
      tenth_r <= tenth_nxt; match_r <= match_nxt; word_r <= word_nxt; acc_r <= acc_nxt;
      fneg_r <= fneg_nxt; fdig_r <= fdig_nxt; fsticky_r <= fsticky_nxt; fnan_r <= fnan_nxt;
      emit_r <= emit_nxt; rd_vld_r <= rd_vld_nxt; rd_idx_r <= rd_idx_nxt;
      etotal_r <= etotal_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end

  // An accepted line end always yields a waiting result or a curve emission.
  a_line_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && in_data.end_of_line) |=> (oval_r || emit_r))
    else $error("line end produced no result");

  // The RAM read pointer never runs past the point count of the line.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_r && rd_vld_r) |-> (CNT_W'(rd_idx_r) < etotal_r))
    else $error("curve read index beyond point count");

  // Outside an emission no RAM read is pending.
  a_no_stray_read: assert property (@(posedge clk) disable iff (!rst_n)
    !emit_r |-> !rd_vld_r)
    else $error("curve read pending outside emission");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the checksummed text frame parser
// Sends $TYPE,PAYLOAD*XX lines one character per request with bursty input
// and a stalling receiver, predicts every result in a local line parser and
// compares each result field by field across several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ctfp_pkg::*;

  // Parser phases, number sub-phases, payload modes and curve fields used by
  // the local line parser that works out the expected results.
  typedef enum int {LP_DOLLAR, LP_DATA, LP_CS1, LP_CS2, LP_TAIL} line_phase_e;
  typedef enum int {NP_LEAD, NP_SIGN, NP_INT, NP_FRAC, NP_WORD, NP_DONE} num_phase_e;
  typedef enum int {PM_NONE, PM_TEMP, PM_INT, PM_CURVE} pay_mode_e;
  typedef enum int {CF_COUNT, CF_TEMP, CF_DUTY, CF_DONE} curve_field_e;

  // Line-building styles for the checksum and framing.
  typedef enum int {
    LS_GOOD, LS_LOWER_HEX, LS_BAD_SUM, LS_NO_STAR, LS_ONE_DIGIT, LS_BAD_HEX,
    LS_NO_DOLLAR, LS_TAIL
  } line_style_e;

  localparam int          POINTS_MAX = 10;
  localparam int          LINE_MAX   = 255;
  localparam longint      MAG_CAP    = 100000000;
  localparam logic [3:0]  FL_NEG     = 4'd1;
  localparam logic [3:0]  FL_DIGIT   = 4'd2;
  localparam logic [3:0]  FL_STICKY  = 4'd4;
  localparam logic [3:0]  FL_NANINF  = 4'd8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ctfp_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ctfp_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FREQ_MIN;
  logic [19:0] cfg_wdata = '0;

  checksummed_text_frame_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Requests waiting to be offered, and the results still owed by the block.
  ctfp_in_t  char_queue[$];
  ctfp_out_t owed_results[$];
  int        fail_count = 0;
  int        lines_sent = 0;
  int        results_seen = 0;

  // Sender and receiver pacing, set per phase by the stimulus block.
  bit        steady_send = 1'b0;
  int        rx_mode = 0;
  bit        long_hold_req = 1'b0;

  // --------------------------------------------------------------------------
  // Local copy of the block: registers and line state.
  // --------------------------------------------------------------------------
  logic [19:0]  lim_freq_lo, lim_freq_hi;
  logic [6:0]   lim_duty_lo;

  int           ln_pos, ln_len;
  logic [7:0]   ln_xor, ln_sum;
  line_phase_e  ln_phase;
  logic [31:0]  ln_tag;
  bit           ln_err;
  pay_mode_e    ln_mode;
  longint       nm_acc;
  logic [3:0]   nm_flags;
  num_phase_e   nm_phase;
  int           nm_tenth, nm_match, nm_word;
  bit           nm_float, nm_seen, nm_frac;
  curve_field_e cv_field;
  int           cv_point, cv_total;
  logic [15:0]  crv_temp[POINTS_MAX];
  logic [7:0]   crv_duty[POINTS_MAX];
  int           crv_count;

  function automatic logic [7:0] lower8(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit blank8(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Returns the digit value of a hex character, or -1.
  function automatic int hex_digit(logic [7:0] c);
    logic [7:0] lc;
    lc = lower8(c);
    if (c >= "0" && c <= "9") return c - "0";
    if (lc >= "a" && lc <= "f") return lc - "a" + 10;
    return -1;
  endfunction

  function automatic logic [7:0] word_char(int w, int m);
    if (w == 0) return (m == 1) ? "a" : "n";
    return (m == 0) ? "i" : ((m == 1) ? "n" : "f");
  endfunction

  function automatic void number_begin(bit is_float);
    nm_phase = NP_LEAD; nm_float = is_float; nm_seen = 0; nm_frac = 0;
    nm_tenth = 0; nm_match = 0; nm_word = 0; nm_acc = 0; nm_flags = '0;
  endfunction

  function automatic longint number_tenths();
    return nm_acc * 10 + nm_tenth;
  endfunction

  function automatic longint number_signed();
    return (nm_flags & FL_NEG) != 0 ? -nm_acc : nm_acc;
  endfunction

  // Feeds one character to the number being read; returns 1 when the
  // character ends the number and is not part of it.
  function automatic bit number_take(logic [7:0] c);
    bit         dig;
    int         d;
    logic [7:0] lc;
    longint     v;
    dig = c >= "0" && c <= "9";
    d   = dig ? c - "0" : 0;
    lc  = lower8(c);
    if (nm_phase == NP_LEAD) begin
      if (blank8(c)) begin
        nm_seen = 1;
        return 0;
      end
      if (c == CH_PLUS || c == CH_MINUS) begin
        if (c == CH_MINUS) nm_flags |= FL_NEG;
        nm_seen = 1; nm_phase = NP_SIGN;
        return 0;
      end
      // No sign: carry on exactly as after one.
      nm_phase = NP_SIGN;
    end
    case (nm_phase)
      NP_SIGN: begin
        if (dig) begin
          nm_acc = d; nm_flags |= FL_DIGIT; nm_phase = NP_INT;
          return 0;
        end
        if (nm_float && c == CH_DOT) begin
          nm_seen = 1; nm_phase = NP_FRAC;
          return 0;
        end
        if (nm_float && (lc == "n" || lc == "i")) begin
          nm_word = (lc == "n") ? 0 : 1; nm_match = 1; nm_seen = 1;
          nm_phase = NP_WORD;
          return 0;
        end
        nm_phase = NP_DONE;
        return 1;
      end
      NP_INT: begin
        if (dig) begin
          v = nm_acc * 10 + d;
          nm_acc = (v > MAG_CAP) ? MAG_CAP : v;
          return 0;
        end
        if (nm_float && c == CH_DOT) begin
          nm_phase = NP_FRAC;
          return 0;
        end
        nm_phase = NP_DONE;
        return 1;
      end
      NP_FRAC: begin
        if (dig) begin
          if (!nm_frac) begin
            nm_tenth = d; nm_frac = 1;
          end else if (d != 0) nm_flags |= FL_STICKY;
          nm_flags |= FL_DIGIT;
          return 0;
        end
        nm_phase = NP_DONE;
        return 1;
      end
      NP_WORD: begin
        if (nm_match < 3 && lc == word_char(nm_word, nm_match)) begin
          nm_match++;
          if (nm_match == 3) nm_flags |= FL_NANINF;
          return 0;
        end
        nm_phase = NP_DONE;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void curve_abort();
    ln_err = 1; cv_field = CF_DONE;
  endfunction

  // Closes one curve field on the character that ended it.
  function automatic void curve_close(logic [7:0] c);
    longint m, v;
    int     t;
    if ((nm_flags & FL_NANINF) != 0 || ((nm_flags & FL_DIGIT) == 0 && nm_seen)) begin
      curve_abort();
      return;
    end
    case (cv_field)
      CF_COUNT: begin
        v = number_signed();
        if (v < 2 || v > POINTS_MAX || c != CH_COMMA) begin
          curve_abort();
          return;
        end
        cv_total = int'(v); cv_point = 0; cv_field = CF_TEMP; number_begin(1);
      end
      CF_TEMP: begin
        m = number_tenths();
        if ((nm_flags & FL_NEG) != 0) t = (m > 32768) ? -32768 : -int'(m);
        else t = (m > 32767) ? 32767 : int'(m);
        if (cv_point < POINTS_MAX) crv_temp[cv_point] = t[15:0];
        if (c != CH_COMMA) begin
          curve_abort();
          return;
        end
        cv_field = CF_DUTY; number_begin(0);
      end
      CF_DUTY: begin
        v = number_signed();
        if (cv_point < POINTS_MAX) crv_duty[cv_point] = v[7:0];
        cv_point++;
        if (cv_point >= cv_total) begin
          cv_field = CF_DONE;
          return;
        end
        if (c != CH_COMMA) begin
          curve_abort();
          return;
        end
        cv_field = CF_TEMP; number_begin(1);
      end
      default: ;
    endcase
  endfunction

  function automatic void payload_take(logic [7:0] c);
    if (ln_mode == PM_TEMP || ln_mode == PM_INT) void'(number_take(c));
    else if (ln_mode == PM_CURVE && cv_field != CF_DONE) begin
      if (number_take(c)) curve_close(c);
    end
  endfunction

  function automatic void line_reset();
    ln_pos = 0; ln_xor = '0; ln_phase = LP_DOLLAR; ln_tag = '0; ln_len = 0;
    ln_sum = '0; ln_err = 0; ln_mode = PM_NONE; cv_field = CF_COUNT;
    cv_point = 0; cv_total = 0;
    number_begin(0);
  endfunction

  function automatic void char_take(logic [7:0] c);
    int h;
    if (ln_pos >= LINE_MAX) ln_err = 1;
    else ln_pos++;
    if (ln_err) return;
    case (ln_phase)
      LP_DOLLAR: begin
        if (c == CH_DOLLAR) ln_phase = LP_DATA;
        else ln_err = 1;
      end
      LP_DATA: begin
        if (c == CH_STAR) begin
          payload_take(c);
          ln_phase = LP_CS1;
        end else begin
          ln_xor ^= c;
          if (ln_len < 4) begin
            ln_tag = {ln_tag[23:0], c};
            ln_len++;
            if (ln_len == 4) begin
              if (ln_tag == TAG_CPU || ln_tag == TAG_GPU) begin
                ln_mode = PM_TEMP; number_begin(1);
              end else if (ln_tag == TAG_MOD || ln_tag == TAG_FRQ || ln_tag == TAG_DUT) begin
                ln_mode = PM_INT; number_begin(0);
              end else if (ln_tag == TAG_FCV) begin
                ln_mode = PM_CURVE; cv_field = CF_COUNT; number_begin(0);
              end
            end
          end else begin
            if (ln_len < 255) ln_len++;
            payload_take(c);
          end
        end
      end
      LP_CS1: begin
        h = hex_digit(c);
        if (h < 0) ln_err = 1;
        else begin
          ln_sum = {h[3:0], 4'd0}; ln_phase = LP_CS2;
        end
      end
      LP_CS2: begin
        h = hex_digit(c);
        if (h < 0) ln_err = 1;
        else begin
          ln_sum[3:0] = h[3:0]; ln_phase = LP_TAIL;
        end
      end
      default: ;
    endcase
  endfunction

  // Works out the results of a finished line and queues them.
  function automatic void line_close();
    ctfp_out_t r;
    longint    v, m;
    bit        ok, sticky, neg, bad;
    int        t;
    r  = '0;
    r.frame_kind  = KIND_REJECT;
    r.last_result = 1'b1;
    v  = number_signed();
    ok = !ln_err && ln_phase == LP_TAIL && ln_len >= 3 && ln_sum == ln_xor;
    if (ok) begin
      if ((ln_tag == TAG_CPU || ln_tag == TAG_GPU) && ln_len >= 6) begin
        m      = number_tenths();
        sticky = (nm_flags & FL_STICKY) != 0;
        neg    = (nm_flags & FL_NEG) != 0;
        bad    = (nm_flags & FL_NANINF) != 0 ||
                 (neg ? (m > 500 || (m == 500 && sticky)) : (m > 1500 || (m == 1500 && sticky)));
        if (!bad) begin
          r.frame_kind  = (ln_tag == TAG_CPU) ? KIND_CPU_TEMP : KIND_GPU_TEMP;
          t             = neg ? -int'(m) : int'(m);
          r.temperature = t[11:0];
        end
      end else if (ln_tag == TAG_STA && ln_len == 5) r.frame_kind = KIND_STATUS;
      else if (ln_tag == TAG_FCQ && ln_len == 5) r.frame_kind = KIND_CURVE_Q;
      else if (ln_tag == TAG_FCV && ln_len >= 6) begin
        if (cv_field == CF_DONE && cv_total >= 2 && cv_total <= POINTS_MAX) begin
          // One result per stored point, the last one flagged.
          for (int i = 0; i < cv_total; i++) begin
            r = '0;
            r.frame_kind  = KIND_CURVE_S;
            r.point_count = cv_total[3:0];
            r.point_index = i[3:0];
            r.point_temp  = crv_temp[i];
            r.point_duty  = crv_duty[i];
            r.last_result = (i + 1 == cv_total);
            owed_results.push_back(r);
          end
          crv_count = cv_total;
          return;
        end
      end else if (ln_tag == TAG_MOD && ln_len >= 5) begin
        if (v >= 1 && v <= 4) begin
          r.frame_kind = KIND_MODE; r.mode_value = v[2:0];
        end
      end else if (ln_tag == TAG_FRQ && ln_len >= 6) begin
        if (v >= longint'(lim_freq_lo) && v <= longint'(lim_freq_hi)) begin
          r.frame_kind = KIND_FREQ; r.frequency = v[19:0];
        end
      end else if (ln_tag == TAG_DUT && ln_len >= 5) begin
        if (v >= longint'(lim_duty_lo) && v <= 100) begin
          r.frame_kind = KIND_DUTY; r.duty_value = v[6:0];
        end
      end else if (ln_tag == TAG_SAF && ln_len == 3) r.frame_kind = KIND_SAFETY;
    end
    owed_results.push_back(r);
  endfunction

  function automatic void parser_accept(ctfp_in_t it);
    char_take(it.rx_byte);
    if (it.end_of_line) begin
      line_close();
      line_reset();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offers queued requests in bursts of random length split by random
  // gaps, or back to back when steady sending is set. A request is predicted
  // in the cycle it is accepted; a request not accepted is held unchanged.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) parser_accept(in_data);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_queue.size() > 0) begin
          in_data  <= char_queue.pop_front();
          in_valid <= 1'b1;
          if (!steady_send) begin
            if (burst_left > 0) burst_left--;
            else begin
              burst_left = $urandom_range(1, 24);
              gap_left   = $urandom_range(1, 6);
            end
          end
        end else in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls on a per-phase pattern. On request it holds off for a
  // long stretch so that a result backs up and the block stalls its input
  // while the sender keeps offering characters.
  // --------------------------------------------------------------------------
  int rx_cycle = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 400;
        out_stall    <= 1'b1;
      end else begin
        case (rx_mode)
          1:       out_stall <= ($urandom_range(0, 2) == 0);
          2:       out_stall <= ((rx_cycle % 9) < 4);
          3:       out_stall <= ($urandom_range(0, 5) != 0);
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result is compared with the oldest one
  // still owed.
  // --------------------------------------------------------------------------
  function automatic void field_check(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    ctfp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        field_check("frame_kind", want.frame_kind, out_data.frame_kind);
        field_check("temperature", want.temperature, out_data.temperature);
        field_check("mode_value", want.mode_value, out_data.mode_value);
        field_check("frequency", want.frequency, out_data.frequency);
        field_check("duty_value", want.duty_value, out_data.duty_value);
        field_check("point_count", want.point_count, out_data.point_count);
        field_check("point_index", want.point_index, out_data.point_index);
        field_check("point_temp", want.point_temp, out_data.point_temp);
        field_check("point_duty", want.point_duty, out_data.point_duty);
        field_check("last_result", want.last_result, out_data.last_result);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic void queue_char(logic [7:0] c, bit eol);
    ctfp_in_t it;
    it.rx_byte     = c;
    it.end_of_line = eol;
    char_queue.push_back(it);
  endfunction

  // Frames a body as $body*XX in the given style and queues it as one line.
  function automatic void queue_line(string body, line_style_e style);
    string      s;
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < body.len(); i++) sum ^= body[i];
    case (style)
      LS_LOWER_HEX: s = {"$", body, "*", $sformatf("%02x", sum)};
      LS_BAD_SUM:   s = {"$", body, "*", $sformatf("%02X", sum ^ (8'd1 << $urandom_range(0, 7)))};
      LS_NO_STAR:   s = {"$", body};
      LS_ONE_DIGIT: s = {"$", body, "*", $sformatf("%01X", sum[7:4])};
      LS_BAD_HEX:   s = {"$", body, "*", $sformatf("%01X", sum[7:4]), "g"};
      LS_NO_DOLLAR: s = {body, "*", $sformatf("%02X", sum)};
      LS_TAIL:      s = {"$", body, "*", $sformatf("%02X", sum), "\r"};
      default:      s = {"$", body, "*", $sformatf("%02X", sum)};
    endcase
    for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
    lines_sent++;
  endfunction

  // A line of arbitrary bytes, upper half of the code space included.
  function automatic void queue_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) queue_char(CH_DOLLAR, i == n - 1);
      else queue_char(8'($urandom_range(0, 255)), i == n - 1);
    end
    lines_sent++;
  endfunction

  function automatic line_style_e pick_style();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return LS_GOOD;
    if (p < 78) return LS_LOWER_HEX;
    if (p < 82) return LS_TAIL;
    if (p < 86) return LS_BAD_SUM;
    if (p < 90) return LS_NO_STAR;
    if (p < 93) return LS_ONE_DIGIT;
    if (p < 96) return LS_BAD_HEX;
    return LS_NO_DOLLAR;
  endfunction

  function automatic string pick_sign();
    case ($urandom_range(0, 3))
      0:       return "-";
      1:       return "+";
      default: return "";
    endcase
  endfunction

  // Temperature text: mostly plain decimals, some near the limits, the odd
  // spelled word, bare fraction, blank prefix, huge value, exponent or empty.
  function automatic string pick_temp();
    case ($urandom_range(0, 11))
      0: return {pick_sign(), "nan"};
      1: return {pick_sign(), "INF"};
      2: return {pick_sign(), ".", $sformatf("%0d", $urandom_range(0, 9))};
      3: return {" ", pick_sign(), $sformatf("%0d", $urandom_range(0, 200))};
      4: return $sformatf("%0d%0d", $urandom_range(1, 99999), $urandom_range(0, 99999));
      5: return {pick_sign(), "50.0", ($urandom_range(0, 1) ? "1" : "0")};
      6: return {"150.0", ($urandom_range(0, 1) ? "01" : "00")};
      7: return {pick_sign(), $sformatf("%0d", $urandom_range(0, 4000)), "e2"};
      8: return "";
      default: return {pick_sign(), $sformatf("%0d.%0d", $urandom_range(0, 160),
                                               $urandom_range(0, 999))};
    endcase
  endfunction

  // Integer text around a pair of bounds.
  function automatic string pick_int(longint lo, longint hi);
    longint v;
    case ($urandom_range(0, 7))
      0: v = lo - 1;
      1: v = lo;
      2: v = hi;
      3: v = hi + 1;
      4: return $sformatf("%0d%0d", $urandom_range(1, 99999), $urandom_range(0, 99999));
      5: return {" ", pick_sign(), $sformatf("%0d", $urandom_range(0, 9))};
      default: v = $urandom_range(0, 2 * int'(hi) + 2) - 1;
    endcase
    return $sformatf("%0d", v);
  endfunction

  // A curve set: mostly well formed, sometimes with a bad count, a broken
  // separator, a missing point or text after the last duty.
  function automatic string pick_curve();
    string s;
    int    n, shown, brk;
    n = $urandom_range(2, POINTS_MAX);
    case ($urandom_range(0, 15))
      0: s = {"FCV,", $sformatf("%0d", $urandom_range(0, 1))};
      1: s = {"FCV,", $sformatf("%0d", $urandom_range(11, 15))};
      2: s = "FCV,-3";
      default: s = {"FCV,", $sformatf("%0d", n)};
    endcase
    shown = ($urandom_range(0, 9) == 0) ? n - 1 : n;
    brk   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2 * n) : -1;
    for (int i = 0; i < shown; i++) begin
      s = {s, (brk == 2 * i) ? ";" : ",", pick_temp()};
      s = {s, (brk == 2 * i + 1) ? ";" : ",", pick_sign(),
           $sformatf("%0d", $urandom_range(0, 400))};
    end
    if ($urandom_range(0, 4) == 0) s = {s, ",xy"};
    return s;
  endfunction

  function automatic void queue_random_line();
    int p;
    p = $urandom_range(0, 99);
    if (p < 6) queue_noise();
    else if (p < 22) queue_line({$urandom_range(0, 1) ? "CPU," : "GPU,", pick_temp()}, pick_style());
    else if (p < 42) queue_line(pick_curve(), pick_style());
    else if (p < 50) queue_line({"MOD,", pick_int(1, 4)}, pick_style());
    else if (p < 60) queue_line({"FRQ,", pick_int(lim_freq_lo, lim_freq_hi)}, pick_style());
    else if (p < 70) queue_line({"DUT,", pick_int(lim_duty_lo, 100)}, pick_style());
    else if (p < 76) queue_line($urandom_range(0, 2) ? "STA,?" : "STA,", pick_style());
    else if (p < 82) queue_line($urandom_range(0, 2) ? "FCQ,1" : "FCQ,12", pick_style());
    else if (p < 88) queue_line($urandom_range(0, 2) ? "SAF" : "SAF,", pick_style());
    else if (p < 94) queue_line({"XYZ,", $sformatf("%0d", $urandom_range(0, 99))}, pick_style());
    else if (p < 97) queue_line($urandom_range(0, 1) ? "AB" : "C", pick_style());
    else begin
      // A line running past the length limit.
      string pad;
      pad = "";
      repeat ($urandom_range(250, 270)) pad = {pad, " "};
      queue_line({"CPU,", pad, "25"}, LS_GOOD);
    end
  endfunction

  // Waits until everything sent has been answered, then lets the block
  // settle before any register is touched.
  task automatic drain();
    while (char_queue.size() > 0 || in_valid || owed_results.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_regs(logic [19:0] f_lo, logic [19:0] f_hi, logic [6:0] d_lo);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_FREQ_MIN; cfg_wdata <= f_lo;
    @(posedge clk);
    cfg_index <= CFG_FREQ_MAX; cfg_wdata <= f_hi;
    @(posedge clk);
    cfg_index <= CFG_MIN_DUTY; cfg_wdata <= {13'd0, d_lo};
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_freq_lo = f_lo; lim_freq_hi = f_hi; lim_duty_lo = d_lo;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, a directed set of lines under the reset register
  // values, then random phases under several settings, extremes first.
  // --------------------------------------------------------------------------
  initial begin
    int chars_before;
    lim_freq_lo = 20'd1000; lim_freq_hi = 20'd100000; lim_duty_lo = 7'd20;
    crv_count = 0;
    for (int i = 0; i < POINTS_MAX; i++) begin
      crv_temp[i] = '0; crv_duty[i] = '0;
    end
    line_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: the limits of each field, every frame kind and the
    // special cases of the line format.
    rx_mode = 0;
    queue_line("CPU,-50.0", LS_GOOD);
    queue_line("GPU,150.0", LS_LOWER_HEX);
    queue_line("GPU,150.01", LS_GOOD);
    queue_line("CPU,-50.00001", LS_GOOD);
    queue_line("CPU, +25.79", LS_TAIL);
    queue_line("CPU,-nan", LS_GOOD);
    queue_line("GPU,InF", LS_GOOD);
    queue_line("STA,?", LS_GOOD);
    queue_line("FCQ,x", LS_GOOD);
    queue_line("SAF", LS_GOOD);
    queue_line("MOD,4", LS_GOOD);
    queue_line("MOD,0", LS_GOOD);
    queue_line("FRQ,1000", LS_GOOD);
    queue_line("FRQ,100001", LS_GOOD);
    queue_line("FRQ,99999999999", LS_GOOD);
    queue_line("DUT,100", LS_GOOD);
    queue_line("DUT,19", LS_GOOD);
    queue_line("FCV,2,-3276.9,255,4000.5,300", LS_GOOD);
    queue_line("FCV,10,1,1,2,2,3,3,4,4,5,5,6,6,7,7,8,8,9,9,10,10", LS_GOOD);
    queue_line("FCV,3,1,1,2,2", LS_GOOD);
    queue_line("FCV,2,nan,1,2,2", LS_GOOD);
    queue_line("FCV,11,1,1", LS_GOOD);
    queue_line("MOD,2", LS_BAD_SUM);
    queue_line("MOD,2", LS_BAD_HEX);
    queue_line("MOD,2", LS_NO_STAR);
    queue_line("AB", LS_GOOD);
    queue_noise();
    drain();

    // Random phases; the receiver's long hold-off falls in the second one.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       write_regs(20'd0, 20'd1000000, 7'd0);
        1:       write_regs(20'd1000000, 20'd1000000, 7'd100);
        2:       write_regs(20'd0, 20'd0, 7'd0);
        default: write_regs(20'($urandom_range(0, 5000)), 20'($urandom_range(5000, 1000000)),
                            7'($urandom_range(0, 100)));
      endcase
      rx_mode     = ph % 4;
      steady_send = (ph == 2);
      if (ph == 1) long_hold_req = 1'b1;
      chars_before = 0;
      while (chars_before < 24) begin
        int n0;
        n0 = char_queue.size();
        queue_random_line();
        chars_before += char_queue.size() - n0;
      end
      drain();
    end

    if (owed_results.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, owed_results.size());
      fail_count++;
    end
    $display("Run covered %0d lines and %0d results over five register settings,",
             lines_sent, results_seen);
    $display("with bursty input, receiver stalls and one long receiver hold-off.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/ctfp_pkg.sv
rtl/ctfp_ram.sv
rtl/checksummed_text_frame_parser.sv
sim/tb.sv
